/* design/metc_pkg.sv */
// Shared types and constants for the Morse element timing classifier.
`default_nettype none

package metc_pkg;

    localparam int COUNT_BITS     = 20;
    localparam int FRACTION_BITS  = 8;
    localparam int DIT_BITS       = COUNT_BITS + FRACTION_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 28;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_DIT   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RATIO     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SAMPLES   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EMA_WEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIT_DAH_RATIO = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHAR_RATIO    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WORD_RATIO    = 3'd6;

    // Register reset values
    localparam logic [27:0] RST_INITIAL_DIT   = 28'd122880;
    localparam logic [11:0] RST_MIN_RATIO     = 12'd128;
    localparam logic [19:0] RST_MIN_SAMPLES   = 20'd80;
    localparam logic [7:0]  RST_EMA_WEIGHT    = 8'd26;
    localparam logic [7:0]  RST_DIT_DAH_RATIO = 8'd32;
    localparam logic [7:0]  RST_CHAR_RATIO    = 8'd40;
    localparam logic [7:0]  RST_WORD_RATIO    = 8'd96;

    // Input actions
    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_FLUSH   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // Element codes
    localparam logic [2:0] EL_NONE = 3'd0;
    localparam logic [2:0] EL_DIT  = 3'd1;
    localparam logic [2:0] EL_DAH  = 3'd2;
    localparam logic [2:0] EL_CHAR = 3'd3;
    localparam logic [2:0] EL_WORD = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic       level;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  element;
        logic [27:0] dit_estimate;
    } t_out_word;

endpackage

`default_nettype wire

/* design/morse_element_timing_classifier_top.sv */
// Top level of the Morse element timing classifier: counters, classifier and handshake.
`default_nettype none

// Morse element timing classifier. Each input word carries one keying sample (or a flush
// or restart action); each accepted word yields exactly one output word holding the element
// code (none, dit, dah, character gap, word gap) and the dit estimate after that step, Q20.8.
// Mark and gap counters saturate at 2^20-1. A dit pulls the estimate toward its own length
// through an EMA with weight ema_weight/256, rounded to nearest. Throughput is one word per
// clock while the output is not stalled; an accepted word passes through the input register
// and then the result register. The rate is set by the state update loop: the dit estimate
// and both counters are computed combinationally from the registered word and the current
// state, with all products (noise floor, dit/dah split, gap thresholds, EMA) formed in
// parallel. A stalled output holds the pipeline; the input side keeps one word in flight.
// Write the configuration registers only while no word is in flight.
module morse_element_timing_classifier_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [metc_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire  [metc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  metc_pkg::t_in_word                    i_in_word,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output metc_pkg::t_out_word                   o_out_word
);

    localparam int CB  = metc_pkg::COUNT_BITS;
    localparam int FB  = metc_pkg::FRACTION_BITS;
    localparam int DB  = metc_pkg::DIT_BITS;
    // product widths
    localparam int FLOOR_W = DB + 12;          // dit * Q4.8 ratio
    localparam int THR_W   = DB + 8;           // dit * Q4.4 ratio
    localparam int SCL_W   = CB + FB + 4;      // count scaled to dit * Q4.4
    localparam int MIX_W   = DB + 10;          // EMA accumulator

    // configuration registers
    logic [27:0] r_initial_dit;
    logic [11:0] r_min_ratio;
    logic [19:0] r_min_samples;
    logic [7:0]  r_ema_weight;
    logic [7:0]  r_dit_dah_ratio;
    logic [7:0]  r_char_ratio;
    logic [7:0]  r_word_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_dit   <= metc_pkg::RST_INITIAL_DIT;
            r_min_ratio     <= metc_pkg::RST_MIN_RATIO;
            r_min_samples   <= metc_pkg::RST_MIN_SAMPLES;
            r_ema_weight    <= metc_pkg::RST_EMA_WEIGHT;
            r_dit_dah_ratio <= metc_pkg::RST_DIT_DAH_RATIO;
            r_char_ratio    <= metc_pkg::RST_CHAR_RATIO;
            r_word_ratio    <= metc_pkg::RST_WORD_RATIO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                metc_pkg::REG_INITIAL_DIT:   r_initial_dit   <= i_cfg_data[27:0];
                metc_pkg::REG_MIN_RATIO:     r_min_ratio     <= i_cfg_data[11:0];
                metc_pkg::REG_MIN_SAMPLES:   r_min_samples   <= i_cfg_data[19:0];
                metc_pkg::REG_EMA_WEIGHT:    r_ema_weight    <= i_cfg_data[7:0];
                metc_pkg::REG_DIT_DAH_RATIO: r_dit_dah_ratio <= i_cfg_data[7:0];
                metc_pkg::REG_CHAR_RATIO:    r_char_ratio    <= i_cfg_data[7:0];
                metc_pkg::REG_WORD_RATIO:    r_word_ratio    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the classifier, which loads the
    // result register. Advance whenever the result register is free or
    // being drained this cycle.
    // ------------------------------------------------------------------
    logic               r_in_valid;
    metc_pkg::t_in_word r_in_word;
    logic               adv;
    logic               fire;

    assign adv        = !o_out_valid || i_out_ready;
    assign fire       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // ------------------------------------------------------------------
    // Classifier state
    // ------------------------------------------------------------------
    logic [CB-1:0] r_mark, n_mark;
    logic [CB-1:0] r_gap, n_gap;
    logic          r_last, n_last;
    logic          r_seen, n_seen;
    logic [DB-1:0] r_dit, n_dit;
    logic [2:0]    n_elem;

    // Mark judgment, always on the current mark count
    logic [FLOOR_W-1:0] floor_prod;
    logic [FLOOR_W-17:0] floor_len;   // product >> (FB + 8)
    logic               mark_noise;
    logic [SCL_W-1:0]   mark_scaled;
    logic [THR_W-1:0]   dah_thr;
    logic               mark_short;
    logic [2:0]         mark_elem;
    logic               mark_dit;
    logic [8:0]         keep_weight;
    logic [MIX_W-1:0]   mix;
    logic [DB-1:0]      ema_dit;

    assign floor_prod = FLOOR_W'(r_dit) * FLOOR_W'(r_min_ratio);
    assign floor_len  = floor_prod[FLOOR_W-1:FB+8];
    // noise when shorter than either the scaled floor or the absolute minimum
    assign mark_noise = (FLOOR_W'(r_mark) < FLOOR_W'(floor_len))
                     || (r_mark < r_min_samples);

    assign mark_scaled = {r_mark, {(FB + 4){1'b0}}};
    assign dah_thr     = THR_W'(r_dit) * THR_W'(r_dit_dah_ratio);
    assign mark_short  = THR_W'(mark_scaled) < dah_thr;

    assign mark_dit  = !mark_noise && mark_short;
    assign mark_elem = mark_noise ? metc_pkg::EL_NONE :
                       (mark_short ? metc_pkg::EL_DIT : metc_pkg::EL_DAH);

    // EMA: ((256 - w) * dit + w * (mark << FB) + 128) >> 8
    assign keep_weight = 9'd256 - {1'b0, r_ema_weight};
    assign mix = (MIX_W'(keep_weight) * MIX_W'(r_dit))
               + (MIX_W'(r_ema_weight) * MIX_W'({r_mark, {FB{1'b0}}}))
               + MIX_W'(128);
    assign ema_dit = mix[8 +: DB];

    // Gap judgment on the current gap count
    logic [SCL_W-1:0] gap_scaled;
    logic [THR_W-1:0] word_thr;
    logic [THR_W-1:0] char_thr;
    logic [2:0]       gap_elem;

    assign gap_scaled = {r_gap, {(FB + 4){1'b0}}};
    assign word_thr   = THR_W'(r_dit) * THR_W'(r_word_ratio);
    assign char_thr   = THR_W'(r_dit) * THR_W'(r_char_ratio);

    always_comb begin
        if (THR_W'(gap_scaled) >= word_thr) begin
            gap_elem = metc_pkg::EL_WORD;
        end else if (THR_W'(gap_scaled) >= char_thr) begin
            gap_elem = metc_pkg::EL_CHAR;
        end else begin
            gap_elem = metc_pkg::EL_NONE;
        end
    end

    // Next state for the word in the input register
    always_comb begin
        n_mark = r_mark;
        n_gap  = r_gap;
        n_last = r_last;
        n_seen = r_seen;
        n_dit  = r_dit;
        n_elem = metc_pkg::EL_NONE;
        case (r_in_word.action)
            metc_pkg::ACT_SAMPLE: begin
                // advance the counter for this sample, holding at full scale
                if (r_in_word.level) begin
                    n_mark = (r_mark == {CB{1'b1}}) ? r_mark : r_mark + CB'(1);
                end else begin
                    n_gap = (r_gap == {CB{1'b1}}) ? r_gap : r_gap + CB'(1);
                end
                // falling edge: the mark just ended
                if (r_last && !r_in_word.level) begin
                    n_elem = mark_elem;
                    if (mark_dit) begin
                        n_dit = ema_dit;
                    end
                    n_mark = '0;
                    n_seen = 1'b1;
                end
                // rising edge: judge the gap only after an earlier mark
                if (!r_last && r_in_word.level) begin
                    if (r_seen && gap_elem != metc_pkg::EL_NONE) begin
                        n_elem = gap_elem;
                    end
                    n_gap = '0;
                end
                n_last = r_in_word.level;
            end
            metc_pkg::ACT_FLUSH: begin
                if (r_mark != '0 && r_seen) begin
                    n_elem = mark_elem;
                    if (mark_dit) begin
                        n_dit = ema_dit;
                    end
                    n_mark = '0;
                end
            end
            metc_pkg::ACT_RESTART: begin
                n_dit  = DB'(r_initial_dit);
                n_mark = '0;
                n_gap  = '0;
                n_last = 1'b0;
                n_seen = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= '0;
            r_gap  <= '0;
            r_last <= 1'b0;
            r_seen <= 1'b0;
            r_dit  <= DB'(metc_pkg::RST_INITIAL_DIT);
        end else if (fire) begin
            r_mark <= n_mark;
            r_gap  <= n_gap;
            r_last <= n_last;
            r_seen <= n_seen;
            r_dit  <= n_dit;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_out_word.element      <= n_elem;
            o_out_word.dit_estimate <= 28'(n_dit);
        end
    end

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the Morse element timing classifier top level.
`timescale 1ns / 1ps

module tb;

    import metc_pkg::*;

    // Action code the block ignores; there is no package constant for it
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // Generous ceiling for the cycle-count watchdog
    localparam int CYCLE_LIMIT = 400_000;

    // Tracks the classifier state, predicts one output word per input word
    // and checks the block's output words against the predictions in order.
    class element_tracker;
        logic [27:0]           init_dit;
        logic [11:0]           floor_ratio;
        logic [19:0]           floor_samples;
        logic [7:0]            ema_w;
        logic [7:0]            split_ratio;
        logic [7:0]            char_ratio;
        logic [7:0]            word_ratio;

        logic [COUNT_BITS-1:0] mark_run;
        logic [COUNT_BITS-1:0] gap_run;
        logic                  prev_level;
        logic                  mark_seen;
        logic [DIT_BITS-1:0]   dit_len;

        t_out_word             expected_words[$];
        int                    mismatch_count;
        int                    words_checked;
        int                    element_hits[0:4];

        function new();
            init_dit      = RST_INITIAL_DIT;
            floor_ratio   = RST_MIN_RATIO;
            floor_samples = RST_MIN_SAMPLES;
            ema_w         = RST_EMA_WEIGHT;
            split_ratio   = RST_DIT_DAH_RATIO;
            char_ratio    = RST_CHAR_RATIO;
            word_ratio    = RST_WORD_RATIO;
            mismatch_count = 0;
            words_checked  = 0;
            foreach (element_hits[k]) element_hits[k] = 0;
            restart_state();
        endfunction

        function void restart_state();
            dit_len    = init_dit;
            mark_run   = '0;
            gap_run    = '0;
            prev_level = 1'b0;
            mark_seen  = 1'b0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] index, logic [27:0] data);
            case (index)
                REG_INITIAL_DIT:   init_dit      = data;
                REG_MIN_RATIO:     floor_ratio   = data[11:0];
                REG_MIN_SAMPLES:   floor_samples = data[19:0];
                REG_EMA_WEIGHT:    ema_w         = data[7:0];
                REG_DIT_DAH_RATIO: split_ratio   = data[7:0];
                REG_CHAR_RATIO:    char_ratio    = data[7:0];
                REG_WORD_RATIO:    word_ratio    = data[7:0];
                default: ;
            endcase
        endfunction

        // Classify a finished mark; a dit also pulls the estimate toward it.
        function logic [2:0] grade_mark(logic [63:0] dur);
            logic [63:0] dit;
            logic [63:0] floor_len;
            logic [63:0] w;
            logic [63:0] mix;
            dit       = dit_len;
            floor_len = (dit * floor_ratio) >> (FRACTION_BITS + 8);
            if (floor_len < floor_samples) floor_len = floor_samples;
            if (dur < floor_len) return EL_NONE;
            if ((dur << (FRACTION_BITS + 4)) < dit * split_ratio) begin
                w   = ema_w;
                mix = (64'd256 - w) * dit + w * (dur << FRACTION_BITS) + 64'd128;
                dit_len = mix >> 8;
                return EL_DIT;
            end
            return EL_DAH;
        endfunction

        function logic [2:0] grade_gap(logic [63:0] dur);
            logic [63:0] dit;
            logic [63:0] scaled;
            dit    = dit_len;
            scaled = dur << (FRACTION_BITS + 4);
            if (scaled >= dit * word_ratio) return EL_WORD;
            if (scaled >= dit * char_ratio) return EL_CHAR;
            return EL_NONE;
        endfunction

        function void note_input(t_in_word w);
            logic [2:0] el;
            logic [2:0] g;
            t_out_word  r;
            el = EL_NONE;
            case (w.action)
                ACT_SAMPLE: begin
                    // Saturate the counter of the current level
                    if (w.level) begin
                        if (!(&mark_run)) mark_run = mark_run + 1'b1;
                    end else begin
                        if (!(&gap_run)) gap_run = gap_run + 1'b1;
                    end
                    if (prev_level && !w.level) begin
                        el        = grade_mark(mark_run);
                        mark_run  = '0;
                        mark_seen = 1'b1;
                    end
                    if (!prev_level && w.level) begin
                        if (mark_seen) begin
                            g = grade_gap(gap_run);
                            if (g != EL_NONE) el = g;
                        end
                        gap_run = '0;
                    end
                    prev_level = w.level;
                end
                ACT_FLUSH: begin
                    if (mark_run != '0 && mark_seen) begin
                        el       = grade_mark(mark_run);
                        mark_run = '0;
                    end
                end
                ACT_RESTART: restart_state();
                default: ;
            endcase
            r.element      = el;
            r.dit_estimate = dit_len;
            expected_words.push_back(r);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report(string what, logic [63:0] want, logic [63:0] got);
            mismatch_count++;
            $display("MISMATCH at output word %0d, %s: expected %0d, got %0d",
                     words_checked, what, want, got);
        endtask

        task check(t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                report("word with nothing pending, element", 0, got.element);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.element !== want.element)
                report("element", want.element, got.element);
            if (got.dit_estimate !== want.dit_estimate)
                report("dit estimate", want.dit_estimate, got.dit_estimate);
            if (want.element <= EL_WORD) element_hits[want.element]++;
        endtask
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    t_in_word                  in_word;
    logic                      out_valid;
    logic                      out_ready;
    t_out_word                 out_word;

    element_tracker            book;
    logic                      quiet_tail;
    int                        words_sent;
    int                        settings_loaded;
    int                        cycle_count;

    morse_element_timing_classifier_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop for a hung handshake or a lost word
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every accepted output word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) book.check(out_word);
    end

    // Receiver: stall in random bursts between runs of ready, hold ready high in the tail
    initial begin
        out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (quiet_tail) begin
                out_ready <= 1'b1;
                @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(40, 200)) @(negedge i_clk);
                else
                    repeat ($urandom_range(1, 30)) @(negedge i_clk);
                if ($urandom_range(0, 2) != 0) begin
                    out_ready <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(negedge i_clk);
                end
            end
        end
    end

    // Offer one word, hold it until accepted, then note it for prediction.
    // Returns at the falling edge after acceptance with valid still high.
    task automatic send_word(input logic [1:0] action, input logic level);
        int gap;
        if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid       <= 1'b1;
        in_word.action <= action;
        in_word.level  <= level;
        do @(posedge i_clk); while (!in_ready);
        book.note_input(in_word);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_level(input logic level, input int count);
        repeat (count) send_word(ACT_SAMPLE, level);
    endtask

    // Drop valid and hold off until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (book.pending() != 0) @(negedge i_clk);
    endtask

    // Write all seven registers while the block is idle
    task automatic load_settings(input logic [27:0] init_dit, input logic [11:0] fl_ratio,
                                 input logic [19:0] fl_samples, input logic [7:0] ema,
                                 input logic [7:0] split, input logic [7:0] chr,
                                 input logic [7:0] wrd);
        logic [27:0] values[7];
        drain();
        repeat (4) @(negedge i_clk);
        values[REG_INITIAL_DIT]   = init_dit;
        values[REG_MIN_RATIO]     = fl_ratio;
        values[REG_MIN_SAMPLES]   = fl_samples;
        values[REG_EMA_WEIGHT]    = ema;
        values[REG_DIT_DAH_RATIO] = split;
        values[REG_CHAR_RATIO]    = chr;
        values[REG_WORD_RATIO]    = wrd;
        for (int k = 0; k < 7; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_BITS'(k);
            cfg_data  <= values[k];
            book.set_reg(CFG_INDEX_BITS'(k), values[k]);
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Keyed traffic around a nominal dit of 'unit' samples: mostly clean
    // dits and dahs with jitter, plus glitches, flushes, restarts and noise.
    task automatic key_stream(input int unit, input int budget);
        int start;
        int pick;
        int len;
        int part;
        start = words_sent;
        while (words_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            len  = unit * (($urandom_range(0, 1) != 0) ? 3 : 1) + int'($urandom_range(0, 2)) - 1;
            if (len < 1) len = 1;
            if (pick < 60) begin
                run_level(1'b1, len);
                case ($urandom_range(0, 2))
                    0: len = unit;
                    1: len = 3 * unit;
                    default: len = 7 * unit;
                endcase
                len = len + int'($urandom_range(0, 2)) - 1;
                run_level(1'b0, (len < 1) ? 1 : len);
            end else if (pick < 70) begin
                // glitch mark
                run_level(1'b1, $urandom_range(1, 2));
                run_level(1'b0, $urandom_range(1, 2 * unit));
            end else if (pick < 76) begin
                // flush mid-mark, then let the mark run on
                part = $urandom_range(1, len);
                run_level(1'b1, part);
                send_word(ACT_FLUSH, 1'($urandom_range(0, 1)));
                run_level(1'b1, $urandom_range(0, 2 * unit));
                run_level(1'b0, $urandom_range(1, 3 * unit));
            end else if (pick < 79) begin
                send_word(ACT_RESTART, 1'($urandom_range(0, 1)));
            end else if (pick < 83) begin
                send_word(ACT_FLUSH, 1'($urandom_range(0, 1)));
            end else if (pick < 86) begin
                send_word(ACT_UNUSED, 1'($urandom_range(0, 1)));
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 8)) send_word(ACT_SAMPLE, 1'($urandom_range(0, 1)));
            end else if (pick < 99) begin
                run_level(1'b0, $urandom_range(1, 12 * unit));
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        int unit;
        int budget;
        book            = new();
        quiet_tail      = 1'b0;
        words_sent      = 0;
        settings_loaded = 0;
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: ignored action and an empty flush
        send_word(ACT_UNUSED, 1'b1);
        send_word(ACT_FLUSH, 1'b0);

        // Directed: 2-sample dit; noise mark, char gap, flushed dit, dah, word gap
        load_settings(28'd512, 12'd128, 20'd2, 8'd26, 8'd32, 8'd16, 8'd64);
        send_word(ACT_RESTART, 1'b1);
        send_word(ACT_FLUSH, 1'b1);
        run_level(1'b1, 1);
        run_level(1'b0, 3);
        run_level(1'b1, 3);
        send_word(ACT_UNUSED, 1'b0);
        send_word(ACT_FLUSH, 1'b0);
        run_level(1'b1, 5);
        run_level(1'b0, 9);
        run_level(1'b1, 1);

        // Random phases across several settings, extremes included
        for (int p = 0; p < 8; p++) begin
            budget = 220;
            if (p >= 6) quiet_tail = 1'b1;
            case (p)
                0: begin
                    unit = 3;
                    load_settings(28'd768, 12'd128, 20'd1, 8'd26, 8'd32, 8'd40, 8'd96);
                end
                2: begin
                    unit = 3;
                    load_settings(28'd0, 12'd0, 20'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                end
                3: begin
                    unit   = 4;
                    budget = 100;
                    load_settings(28'hFFFFFFF, 12'hFFF, 20'hFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                end
                4: begin
                    unit = 1;
                    load_settings(28'd256, 12'd0, 20'd0, 8'hFF, 8'hFF, 8'd0, 8'hFF);
                end
                default: begin
                    unit = $urandom_range(1, 6);
                    load_settings(28'(unit * 256 + $urandom_range(0, 255)),
                                  12'($urandom_range(0, 300)), 20'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(16, 56)),
                                  8'($urandom_range(16, 64)), 8'($urandom_range(48, 160)));
                end
            endcase
            send_word(ACT_RESTART, 1'b0);
            key_stream(unit, budget);
        end

        drain();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d input words over %0d register settings, extremes included",
                 words_sent, settings_loaded);
        $display("Checked %0d words: %0d dit, %0d dah, %0d char gap, %0d word gap, %0d none",
                 book.words_checked, book.element_hits[EL_DIT], book.element_hits[EL_DAH],
                 book.element_hits[EL_CHAR], book.element_hits[EL_WORD],
                 book.element_hits[EL_NONE]);
        if (book.mismatch_count == 0 && book.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/metc_pkg.sv
design/morse_element_timing_classifier_top.sv
dv/tb.sv
